### hdl/efo_pkg.sv
// Shared types, constants and the microcode program for the expiring overwrite FIFO.
package efo_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned CODE_BITS = 8;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned SEQ_W     = 32;
  localparam int unsigned LIFE_W    = 16;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned STEP_W    = 4;

  localparam logic [LIFE_W-1:0] LIFE_RESET = LIFE_W'(150);
  localparam logic [SEQ_W-1:0]  SEQ_RESET  = SEQ_W'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH    = 2'd0,
    MODE_CONSUME = 2'd1,
    MODE_CLEAR   = 2'd2,
    MODE_SIZE    = 2'd3
  } mode_e;

  // Jump conditions evaluated by the sequencer
  typedef enum logic [2:0] {
    COND_ALWAYS   = 3'd0,
    COND_IN_VALID = 3'd1,
    COND_IS_CLEAR = 3'd2,
    COND_EXPIRED  = 3'd3,
    COND_IS_PUSH  = 3'd4,
    COND_IS_CONS  = 3'd5,
    COND_FULL     = 3'd6,
    COND_OUT_FREE = 3'd7
  } cond_e;

  typedef logic [STEP_W-1:0] step_t;

  // Program addresses
  localparam step_t S_FETCH  = 4'd0;
  localparam step_t S_DECODE = 4'd1;
  localparam step_t S_RDHEAD = 4'd2;
  localparam step_t S_CHECK  = 4'd3;
  localparam step_t S_DISP1  = 4'd4;
  localparam step_t S_DISP2  = 4'd5;
  localparam step_t S_PFULL  = 4'd6;
  localparam step_t S_PWRITE = 4'd7;
  localparam step_t S_CONS   = 4'd8;
  localparam step_t S_CLR    = 4'd9;
  localparam step_t S_DONE   = 4'd10;

  // Datapath operations; all but accept act only when the condition holds
  typedef struct packed {
    logic accept;
    logic init_res;
    logic drop;
    logic write;
    logic consume;
    logic clr;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    cond_e cond;
    step_t tgt_t;
    step_t tgt_f;
    ctrl_t ops;
  } uword_t;

  // Status from datapath and ports towards the sequencer
  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic is_clear;
    logic is_push;
    logic is_cons;
    logic expired;
    logic full;
  } status_t;

  localparam ctrl_t OPS_NONE    = '{default: 1'b0};
  localparam ctrl_t OPS_ACCEPT  = '{accept: 1'b1, default: 1'b0};
  localparam ctrl_t OPS_INIT    = '{init_res: 1'b1, default: 1'b0};
  localparam ctrl_t OPS_DROP    = '{drop: 1'b1, default: 1'b0};
  localparam ctrl_t OPS_WRITE   = '{write: 1'b1, default: 1'b0};
  localparam ctrl_t OPS_CONSUME = '{consume: 1'b1, default: 1'b0};
  localparam ctrl_t OPS_CLR     = '{clr: 1'b1, default: 1'b0};
  localparam ctrl_t OPS_EMIT    = '{emit: 1'b1, default: 1'b0};

  // Microcode program
  function automatic uword_t ucode_rom(input step_t addr);
    uword_t w;
    case (addr)
      S_FETCH:  w = '{COND_IN_VALID, S_DECODE, S_FETCH,  OPS_ACCEPT};
      S_DECODE: w = '{COND_IS_CLEAR, S_CLR,    S_RDHEAD, OPS_NONE};
      S_RDHEAD: w = '{COND_ALWAYS,   S_CHECK,  S_CHECK,  OPS_INIT};
      S_CHECK:  w = '{COND_EXPIRED,  S_RDHEAD, S_DISP1,  OPS_DROP};
      S_DISP1:  w = '{COND_IS_PUSH,  S_PFULL,  S_DISP2,  OPS_NONE};
      S_DISP2:  w = '{COND_IS_CONS,  S_CONS,   S_DONE,   OPS_NONE};
      S_PFULL:  w = '{COND_FULL,     S_PWRITE, S_PWRITE, OPS_DROP};
      S_PWRITE: w = '{COND_ALWAYS,   S_DONE,   S_DONE,   OPS_WRITE};
      S_CONS:   w = '{COND_ALWAYS,   S_DONE,   S_DONE,   OPS_CONSUME};
      S_CLR:    w = '{COND_ALWAYS,   S_DONE,   S_DONE,   OPS_CLR};
      S_DONE:   w = '{COND_OUT_FREE, S_FETCH,  S_DONE,   OPS_EMIT};
      default:  w = '{COND_ALWAYS,   S_FETCH,  S_FETCH,  OPS_NONE};
    endcase
    return w;
  endfunction

endpackage

### hdl/efo_sequencer.sv
// Step counter and jump logic that runs the microcode program.
module efo_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  efo_pkg::status_t status_i,
  output efo_pkg::ctrl_t   ctrl_o
);

  efo_pkg::step_t  step_q, step_d;
  efo_pkg::uword_t word;
  logic            cond_true;

  // Fetch the control word of the current step
  assign word = efo_pkg::ucode_rom(step_q);

  // Evaluate the jump condition
  always_comb begin
    case (word.cond)
      efo_pkg::COND_ALWAYS:   cond_true = 1'b1;
      efo_pkg::COND_IN_VALID: cond_true = status_i.in_valid;
      efo_pkg::COND_IS_CLEAR: cond_true = status_i.is_clear;
      efo_pkg::COND_EXPIRED:  cond_true = status_i.expired;
      efo_pkg::COND_IS_PUSH:  cond_true = status_i.is_push;
      efo_pkg::COND_IS_CONS:  cond_true = status_i.is_cons;
      efo_pkg::COND_FULL:     cond_true = status_i.full;
      efo_pkg::COND_OUT_FREE: cond_true = status_i.out_free;
      default:                cond_true = 1'b0;
    endcase
  end

  assign step_d = cond_true ? word.tgt_t : word.tgt_f;

  // Gate the operations with the condition; accept drives ready on its own
  always_comb begin
    ctrl_o          = word.ops & {$bits(efo_pkg::ctrl_t){cond_true}};
    ctrl_o.accept   = word.ops.accept;
  end

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= efo_pkg::S_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

`ifndef SYNTHESIS
  // Ready is offered only at the fetch step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.accept |-> step_q == efo_pkg::S_FETCH)
    else $error("ready raised outside the fetch step");
  // An accepted item always leads to its decode step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.accept && status_i.in_valid) |=> step_q == efo_pkg::S_DECODE)
    else $error("accepted item not decoded");
  // An emitted result always returns to fetch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.emit |=> step_q == efo_pkg::S_FETCH)
    else $error("emit not followed by fetch");
`endif

endmodule

### hdl/efo_datapath.sv
// Ring buffer storage, pointers, sequence counter and result registers.
module efo_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  efo_pkg::ctrl_t                  ctrl_i,
  input  logic                            in_valid_i,
  input  logic [efo_pkg::MODE_W-1:0]      mode_i,
  input  logic [efo_pkg::TIME_W-1:0]      now_ms_i,
  input  logic [efo_pkg::CODE_BITS-1:0]   input_code_i,
  input  logic                            cfg_we_i,
  input  logic [efo_pkg::LIFE_W-1:0]      cfg_wdata_i,
  output efo_pkg::status_t                status_o,
  output logic                            ok_o,
  output logic [efo_pkg::CODE_BITS-1:0]   entry_code_o,
  output logic [efo_pkg::SEQ_W-1:0]       entry_sequence_o,
  output logic [efo_pkg::TIME_W-1:0]      entry_time_ms_o,
  output logic [efo_pkg::CNT_W-1:0]       live_count_o
);

  localparam int unsigned IW = efo_pkg::IDX_W;
  localparam int unsigned CW = efo_pkg::CNT_W;
  localparam logic [IW:0] DEPTH_W = (IW + 1)'(efo_pkg::DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(efo_pkg::DEPTH - 1);

  logic [efo_pkg::CODE_BITS-1:0] code_mem [efo_pkg::DEPTH];
  logic [efo_pkg::SEQ_W-1:0]     seq_mem  [efo_pkg::DEPTH];
  logic [efo_pkg::TIME_W-1:0]    time_mem [efo_pkg::DEPTH];

  logic [efo_pkg::MODE_W-1:0]    mode_q;
  logic [efo_pkg::TIME_W-1:0]    now_q;
  logic [efo_pkg::CODE_BITS-1:0] code_q;
  logic [efo_pkg::CODE_BITS-1:0] rd_code_q;
  logic [efo_pkg::SEQ_W-1:0]     rd_seq_q;
  logic [efo_pkg::TIME_W-1:0]    rd_time_q;
  logic [IW-1:0]                 head_q, head_d;
  logic [CW-1:0]                 count_q, count_d;
  logic [efo_pkg::SEQ_W-1:0]     seq_q, seq_d;
  logic [efo_pkg::LIFE_W-1:0]    life_q;
  logic                          res_ok_q;
  logic [efo_pkg::CODE_BITS-1:0] res_code_q;
  logic [efo_pkg::SEQ_W-1:0]     res_seq_q;
  logic [efo_pkg::TIME_W-1:0]    res_time_q;

  logic [IW-1:0]                 head_inc;
  logic [IW:0]                   tail_sum;
  logic [IW-1:0]                 tail;
  logic [efo_pkg::TIME_W-1:0]    age;
  logic                          nonempty;

  // Pointer arithmetic
  assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + IW'(1);
  assign tail_sum = {1'b0, head_q} + (IW + 1)'(count_q);
  always_comb begin
    if (tail_sum >= DEPTH_W) begin
      tail = IW'(tail_sum - DEPTH_W);
    end else begin
      tail = IW'(tail_sum);
    end
  end

  // Age of the front entry against the lifetime
  assign nonempty = (count_q != '0);
  assign age      = now_q - rd_time_q;

  always_comb begin
    status_o          = '0;
    status_o.in_valid = in_valid_i;
    status_o.out_free = 1'b0;
    status_o.is_clear = (mode_q == efo_pkg::MODE_CLEAR);
    status_o.is_push  = (mode_q == efo_pkg::MODE_PUSH);
    status_o.is_cons  = (mode_q == efo_pkg::MODE_CONSUME);
    status_o.expired  = nonempty &&
                        (age > {{(efo_pkg::TIME_W - efo_pkg::LIFE_W){1'b0}}, life_q});
    status_o.full     = (count_q == CW'(efo_pkg::DEPTH));
  end

  // Next pointer, count and sequence values
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    seq_d   = seq_q;
    if (ctrl_i.clr) begin
      head_d  = '0;
      count_d = '0;
    end else if (ctrl_i.drop || (ctrl_i.consume && nonempty)) begin
      head_d  = head_inc;
      count_d = count_q - CW'(1);
    end else if (ctrl_i.write) begin
      count_d = count_q + CW'(1);
      seq_d   = seq_q + efo_pkg::SEQ_W'(1);
    end
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      seq_q   <= efo_pkg::SEQ_RESET;
      life_q  <= efo_pkg::LIFE_RESET;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      seq_q   <= seq_d;
      if (cfg_we_i) begin
        life_q <= cfg_wdata_i;
      end
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
    end else if (ctrl_i.accept && in_valid_i) begin
      mode_q <= mode_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept && in_valid_i) begin
      now_q  <= now_ms_i;
      code_q <= input_code_i;
    end
  end

  // Write at the tail, read the head into registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.write) begin
      code_mem[tail] <= code_q;
      seq_mem[tail]  <= seq_q;
      time_mem[tail] <= now_q;
    end
    rd_code_q <= code_mem[head_q];
    rd_seq_q  <= seq_mem[head_q];
    rd_time_q <= time_mem[head_q];
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.init_res) begin
      res_ok_q   <= 1'b1;
      res_code_q <= '0;
      res_seq_q  <= '0;
      res_time_q <= '0;
    end else if (ctrl_i.consume) begin
      if (nonempty) begin
        res_code_q <= rd_code_q;
        res_seq_q  <= rd_seq_q;
        res_time_q <= rd_time_q;
      end else begin
        res_ok_q <= 1'b0;
      end
    end else if (ctrl_i.clr) begin
      res_ok_q   <= 1'b1;
      res_code_q <= '0;
      res_seq_q  <= '0;
      res_time_q <= '0;
    end
  end

  assign ok_o             = res_ok_q;
  assign entry_code_o     = res_code_q;
  assign entry_sequence_o = res_seq_q;
  assign entry_time_ms_o  = res_time_q;
  assign live_count_o     = count_q;

`ifndef SYNTHESIS
  // The fill count never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(efo_pkg::DEPTH))
    else $error("fill count above depth");
  // A write finds a free slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.write |-> count_q < CW'(efo_pkg::DEPTH))
    else $error("write into a full buffer");
  // A drop always has an entry to remove
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.drop |-> nonempty)
    else $error("drop from an empty buffer");
`endif

endmodule

### hdl/expiring_overwrite_fifo.sv
// Top level of the expiring overwrite FIFO: ports, output register and wiring.
//
// channel   | direction | tdata fields (low bit first)              | handshake
// s_axis    | in        | mode, now_ms, input_code (48 bits)        | tvalid/tready
// m_axis    | out       | ok, entry_code, entry_sequence,           | tvalid/tready
//           |           | entry_time_ms, live_count (80 bits)       |
// cfg       | in        | lifetime_ms (16 bits)                     | write enable
//
// One item at a time, driven by a microcoded step counter. Clear runs decode and
// clear; other modes run decode, head read and age check, where each expired entry
// dropped repeats head read and age check, then dispatch to push, consume or size.
// The output register lets the next item be accepted while a result waits;
// a new result waits at the final step until that register is free.
// Reset clears pointers and count, sets the sequence counter to 1 and the
// lifetime to 150 ms; slot contents are not cleared.
module expiring_overwrite_fifo (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // mode[1:0], now_ms[33:2], input_code[41:34], zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // ok[0], entry_code[8:1], entry_sequence[40:9],
                                     // entry_time_ms[72:41], live_count[77:73], zero
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  efo_pkg::ctrl_t   ctrl;
  efo_pkg::status_t dp_status;
  efo_pkg::status_t status;

  logic                             res_ok;
  logic [efo_pkg::CODE_BITS-1:0]    res_code;
  logic [efo_pkg::SEQ_W-1:0]        res_seq;
  logic [efo_pkg::TIME_W-1:0]       res_time;
  logic [efo_pkg::CNT_W-1:0]        res_count;
  logic                             out_valid_q;
  logic [79:0]                      out_data_q;
  logic                             out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  // Merge the output-side status into the datapath status
  always_comb begin
    status          = dp_status;
    status.out_free = out_free;
  end

  efo_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  efo_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .in_valid_i       (s_axis_tvalid),
    .mode_i           (s_axis_tdata[1:0]),
    .now_ms_i         (s_axis_tdata[33:2]),
    .input_code_i     (s_axis_tdata[41:34]),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .status_o         (dp_status),
    .ok_o             (res_ok),
    .entry_code_o     (res_code),
    .entry_sequence_o (res_seq),
    .entry_time_ms_o  (res_time),
    .live_count_o     (res_count)
  );

  assign s_axis_tready = ctrl.accept;

  // Hold the result until taken; load a new one on emit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      out_data_q <= {2'b00, res_count, res_time, res_seq, res_code, res_ok};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### test/tb.sv
// Self-checking testbench for the expiring overwrite FIFO: driver, monitor and predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 8 + 2 * efo_pkg::DEPTH + 8;
  localparam int unsigned PHASE_ITEMS = 130;
  localparam int unsigned PRINT_LIMIT = 40;

  typedef struct packed {
    efo_pkg::mode_e             mode;
    logic [efo_pkg::TIME_W-1:0] now_ms;
    logic [7:0]                 code;
  } fifo_op_t;

  typedef struct packed {
    logic                       ok;
    logic [7:0]                 code;
    logic [efo_pkg::SEQ_W-1:0]  sequence_no;
    logic [efo_pkg::TIME_W-1:0] stamp_ms;
    logic [efo_pkg::CNT_W-1:0]  live;
  } fifo_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  // Mirror of the ring buffer and its register
  logic [7:0]                 mirror_code [efo_pkg::DEPTH];
  logic [efo_pkg::SEQ_W-1:0]  mirror_seq  [efo_pkg::DEPTH];
  logic [efo_pkg::TIME_W-1:0] mirror_time [efo_pkg::DEPTH];
  logic [efo_pkg::IDX_W-1:0]  mirror_head = '0;
  logic [efo_pkg::CNT_W-1:0]  mirror_count = '0;
  logic [efo_pkg::SEQ_W-1:0]  mirror_next_seq = efo_pkg::SEQ_RESET;
  logic [efo_pkg::LIFE_W-1:0] mirror_life_ms = efo_pkg::LIFE_RESET;

  fifo_op_t    pending_ops[$];
  fifo_reply_t awaited_replies[$];
  fifo_op_t    offered;
  logic [efo_pkg::TIME_W-1:0] stamp_ms;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  bit          steady_flow = 1'b0;

  expiring_overwrite_fifo i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  task automatic log_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Apply one item to the mirror and return the reply it should produce
  function automatic fifo_reply_t fifo_step(input fifo_op_t op);
    fifo_reply_t               r;
    logic [efo_pkg::IDX_W-1:0] slot;
    r = '0;
    r.ok = 1'b1;
    if (op.mode == efo_pkg::MODE_CLEAR) begin
      mirror_head = '0;
      mirror_count = '0;
    end else begin
      // Drop stale entries from the front, age taken with wrap
      while (mirror_count != 0 &&
             (op.now_ms - mirror_time[mirror_head]) >
             efo_pkg::TIME_W'(mirror_life_ms)) begin
        mirror_head++;
        mirror_count--;
      end
      if (op.mode == efo_pkg::MODE_PUSH) begin
        // Make room by discarding the oldest entry when full
        if (mirror_count == efo_pkg::CNT_W'(efo_pkg::DEPTH)) begin
          mirror_head++;
          mirror_count--;
        end
        slot = mirror_head + mirror_count[efo_pkg::IDX_W-1:0];
        mirror_code[slot] = op.code;
        mirror_seq[slot] = mirror_next_seq;
        mirror_time[slot] = op.now_ms;
        mirror_next_seq++;
        mirror_count++;
      end else if (op.mode == efo_pkg::MODE_CONSUME) begin
        if (mirror_count == 0) begin
          r.ok = 1'b0;
        end else begin
          r.code = mirror_code[mirror_head];
          r.sequence_no = mirror_seq[mirror_head];
          r.stamp_ms = mirror_time[mirror_head];
          mirror_head++;
          mirror_count--;
        end
      end
    end
    r.live = mirror_count;
    return r;
  endfunction

  // Driver: predict accepted items, then offer the next one or idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mirror_life_ms = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_replies.push_back(fifo_step(offered));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_ops.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (!steady_flow && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 6);
          s_axis_tvalid <= 1'b0;
        end else begin
          offered = pending_ops.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {6'b0, offered.code, offered.now_ms, offered.mode};
        end
      end
    end
  end

  // Monitor: check each accepted reply and vary the ready
  always @(posedge clk_i) begin
    fifo_reply_t got;
    fifo_reply_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.ok = m_axis_tdata[0];
        got.code = m_axis_tdata[8:1];
        got.sequence_no = m_axis_tdata[40:9];
        got.stamp_ms = m_axis_tdata[72:41];
        got.live = m_axis_tdata[77:73];
        if (awaited_replies.size() == 0) begin
          log_mismatch($sformatf("reply %h with no item outstanding", got));
        end else begin
          want = awaited_replies.pop_front();
          if (got.ok !== want.ok)
            log_mismatch($sformatf("ok %b, want %b", got.ok, want.ok));
          if (got.code !== want.code)
            log_mismatch($sformatf("entry_code %h, want %h", got.code, want.code));
          if (got.sequence_no !== want.sequence_no)
            log_mismatch($sformatf("entry_sequence %0d, want %0d",
                                   got.sequence_no, want.sequence_no));
          if (got.stamp_ms !== want.stamp_ms)
            log_mismatch($sformatf("entry_time_ms %h, want %h", got.stamp_ms, want.stamp_ms));
          if (got.live !== want.live)
            log_mismatch($sformatf("live_count %0d, want %0d", got.live, want.live));
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 4) == 0) begin
        recv_stall = $urandom_range(0, 6);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: give up after a long stretch with no handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic queue_op(input efo_pkg::mode_e m, input logic [efo_pkg::TIME_W-1:0] now,
                          input logic [7:0] code);
    fifo_op_t op;
    op.mode = m;
    op.now_ms = now;
    op.code = code;
    pending_ops.push_back(op);
  endtask

  // Mostly small time steps so entries live long enough to fill the ring
  task automatic queue_random_ops(input int unsigned count,
                                  input logic [efo_pkg::LIFE_W-1:0] life);
    int unsigned    pick;
    efo_pkg::mode_e m;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) m = efo_pkg::MODE_PUSH;
      else if (pick < 75) m = efo_pkg::MODE_CONSUME;
      else if (pick < 92) m = efo_pkg::MODE_SIZE;
      else m = efo_pkg::MODE_CLEAR;
      pick = $urandom_range(0, 99);
      if (pick >= 96) stamp_ms = $urandom();
      else if (pick >= 80) stamp_ms += $urandom_range(0, 2 * life + 2);
      else if (pick >= 40) stamp_ms += $urandom_range(0, life / 8 + 1);
      queue_op(m, stamp_ms, 8'($urandom()));
    end
  endtask

  // Hold until nothing is queued, offered or awaited
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_ops.size() != 0 || s_axis_tvalid || awaited_replies.size() != 0);
  endtask

  task automatic set_lifetime(input logic [efo_pkg::LIFE_W-1:0] value);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [efo_pkg::LIFE_W-1:0] life,
                           input logic [efo_pkg::TIME_W-1:0] start_ms);
    set_lifetime(life);
    stamp_ms = start_ms;
    queue_random_ops(PHASE_ITEMS, life);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty consume, wrap of time, expiry boundary, clear, overflow
    queue_op(efo_pkg::MODE_CONSUME, 32'd0, 8'h00);
    queue_op(efo_pkg::MODE_PUSH, 32'd0, 8'h00);
    queue_op(efo_pkg::MODE_PUSH, 32'hFFFF_FFFF, 8'hFF);
    queue_op(efo_pkg::MODE_PUSH, 32'd5, 8'hA5);
    queue_op(efo_pkg::MODE_CONSUME, 32'd155, 8'h3C);
    queue_op(efo_pkg::MODE_CLEAR, 32'd0, 8'h00);
    for (int unsigned k = 0; k <= efo_pkg::DEPTH; k++) begin
      queue_op(efo_pkg::MODE_PUSH, 32'd1000 + k, 8'(8'h11 * k));
    end
    queue_op(efo_pkg::MODE_SIZE, 32'd1000 + efo_pkg::DEPTH + 150, 8'hFF);
    queue_op(efo_pkg::MODE_CONSUME, 32'h8000_0000, 8'h00);

    // Random phases across the lifetime range
    run_phase(16'hFFFF, $urandom());
    run_phase(16'd0, $urandom());
    run_phase(16'd1, 32'hFFFF_FF00);
    run_phase(16'($urandom_range(2, 2000)), $urandom());
    run_phase(16'd150, $urandom());
    wait_drained();
    steady_flow = 1'b1;
    run_phase(16'($urandom_range(0, 65535)), $urandom());

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (awaited_replies.size() != 0) begin
      log_mismatch($sformatf("%0d replies never arrived", awaited_replies.size()));
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/efo_pkg.sv
hdl/efo_sequencer.sv
hdl/efo_datapath.sv
hdl/expiring_overwrite_fifo.sv
test/tb.sv
